// ===== sv/hpp_pkg.sv =====
package hpp_pkg;

    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 10;
    localparam int POS_W     = 4;
    localparam int MATCH_LEN = 10;

    localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RESET = 10'd255;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [POS_W-1:0] MATCH_FULL = 4'd10;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_KEY    = 3'd1,
        PH_COLON  = 3'd2,
        PH_SPACE  = 3'd3,
        PH_VALUE  = 3'd4,
        PH_CR     = 3'd5,
        PH_LF     = 3'd6,
        PH_END_CR = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_SKIP     = 3'd0,
        ROLE_KEY      = 3'd1,
        ROLE_SEP      = 3'd2,
        ROLE_VALUE    = 3'd3,
        ROLE_LINE_END = 3'd4
    } role_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_KEY_BREAK = 3'd1,
        ERR_NO_SPACE  = 3'd2,
        ERR_TOO_LONG  = 3'd3,
        ERR_CR_NO_LF  = 3'd4,
        ERR_EARLY_END = 3'd5
    } err_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             ok;
    } match_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        role_t             role;
        logic              pair_done;
        logic              block_done;
        logic              conn_persist;
        err_t              error_code;
    } result_t;

    // "Connection"
    function automatic logic [BYTE_W-1:0] conn_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h63;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h6F;
            4'd9:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "keep-alive"
    function automatic logic [BYTE_W-1:0] ka_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            4'd0:    c = 8'h6B;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h70;
            4'd4:    c = 8'h2D;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h6C;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h76;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Advance a match position by one byte, or drop the match flag.
    function automatic match_t match_step(input logic             is_value,
                                          input logic [POS_W-1:0] pos,
                                          input logic             ok,
                                          input logic [BYTE_W-1:0] b);
        match_t            m;
        logic [BYTE_W-1:0] c;
        c = is_value ? ka_char(pos) : conn_char(pos);
        m.pos = pos;
        m.ok  = 1'b0;
        if (ok && (pos < MATCH_FULL) && (c == b))
        begin
            m.pos = pos + 4'd1;
            m.ok  = 1'b1;
        end
        return m;
    endfunction

endpackage

// ===== sv/hpp_in_if.sv =====
interface hpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_data;

    modport source (output valid, output byte_in, output end_of_data, input ready);
    modport sink   (input valid, input byte_in, input end_of_data, output ready);
endinterface

// ===== sv/hpp_out_if.sv =====
interface hpp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] role;
    logic       pair_done;
    logic       block_done;
    logic       conn_persist;
    logic [2:0] error_code;

    modport source (output valid, output byte_out, output role, output pair_done,
                    output block_done, output conn_persist, output error_code,
                    input ready);
    modport sink   (input valid, input byte_out, input role, input pair_done,
                    input block_done, input conn_persist, input error_code,
                    output ready);
endinterface

// ===== sv/hpp_core.sv =====
module hpp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [hpp_pkg::BYTE_W-1:0]    byte_in,
    input  logic                          end_of_data,
    input  logic [hpp_pkg::LIMIT_W-1:0]   value_limit,
    output hpp_pkg::result_t              result
);
    import hpp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LIMIT_W-1:0] offset_reg, offset_next;
    logic [POS_W-1:0]   kpos_reg, kpos_next;
    logic               kok_reg, kok_next;
    logic [POS_W-1:0]   vpos_reg, vpos_next;
    logic               vok_reg, vok_next;
    logic               seen_reg, seen_next;

    role_t              role;
    err_t               err;
    logic               pair;
    logic               done;
    logic               is_break;
    logic [LIMIT_W:0]   offset_inc;
    match_t             km;
    match_t             vm;

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        kpos_next   = kpos_reg;
        kok_next    = kok_reg;
        vpos_next   = vpos_reg;
        vok_next    = vok_reg;
        seen_next   = seen_reg;
        role        = ROLE_SKIP;
        err         = ERR_NONE;
        pair        = 1'b0;
        done        = 1'b0;
        is_break    = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);
        offset_inc  = {1'b0, offset_reg} + {{LIMIT_W{1'b0}}, 1'b1};
        km          = match_step(1'b0, kpos_reg, kok_reg, byte_in);
        vm          = match_step(1'b1, vpos_reg, vok_reg, byte_in);

        unique case (phase_reg)
            PH_START, PH_LF:
            begin
                if ((phase_reg == PH_LF) && (byte_in == CHAR_CR))
                begin
                    role       = ROLE_LINE_END;
                    phase_next = PH_END_CR;
                end
                else if ((phase_reg == PH_START) && is_break)
                begin
                    role = ROLE_SKIP;
                end
                else
                begin
                    // new key: restart the Connection match
                    km         = match_step(1'b0, '0, 1'b1, byte_in);
                    kpos_next  = km.pos;
                    kok_next   = km.ok;
                    role       = ROLE_KEY;
                    phase_next = PH_KEY;
                end
            end
            PH_KEY:
            begin
                if (byte_in == CHAR_COLON)
                begin
                    role       = ROLE_SEP;
                    phase_next = PH_COLON;
                end
                else if (is_break)
                begin
                    err = ERR_KEY_BREAK;
                end
                else
                begin
                    kpos_next = km.pos;
                    kok_next  = km.ok;
                    role      = ROLE_KEY;
                end
            end
            PH_COLON:
            begin
                if (byte_in == CHAR_SPACE)
                begin
                    role       = ROLE_SEP;
                    phase_next = PH_SPACE;
                end
                else
                begin
                    err = ERR_NO_SPACE;
                end
            end
            PH_SPACE:
            begin
                // first value byte is taken whatever it is
                vm          = match_step(1'b1, '0, 1'b1, byte_in);
                offset_next = '0;
                vpos_next   = vm.pos;
                vok_next    = vm.ok;
                role        = ROLE_VALUE;
                phase_next  = PH_VALUE;
            end
            PH_VALUE:
            begin
                if (byte_in == CHAR_CR)
                begin
                    role       = ROLE_LINE_END;
                    phase_next = PH_CR;
                end
                else if (offset_inc > {1'b0, value_limit})
                begin
                    err = ERR_TOO_LONG;
                end
                else
                begin
                    offset_next = offset_inc[LIMIT_W-1:0];
                    vpos_next   = vm.pos;
                    vok_next    = vm.ok;
                    role        = ROLE_VALUE;
                end
            end
            PH_CR:
            begin
                if (byte_in == CHAR_LF)
                begin
                    role       = ROLE_LINE_END;
                    pair       = 1'b1;
                    phase_next = PH_LF;
                    if (kok_reg && (kpos_reg == MATCH_FULL))
                    begin
                        seen_next = vok_reg && (vpos_reg == MATCH_FULL);
                    end
                end
                else
                begin
                    err = ERR_CR_NO_LF;
                end
            end
            PH_END_CR:
            begin
                if (byte_in == CHAR_LF)
                begin
                    role = ROLE_LINE_END;
                    done = 1'b1;
                end
                else
                begin
                    err = ERR_CR_NO_LF;
                end
            end
            default:
            begin
                err = ERR_NONE;
            end
        endcase

        if ((err == ERR_NONE) && !done && end_of_data)
        begin
            err = ERR_EARLY_END;
        end

        result.byte_out     = byte_in;
        result.role         = (err == ERR_NONE) ? role : ROLE_SKIP;
        result.pair_done    = (err == ERR_NONE) && pair;
        result.block_done   = (err == ERR_NONE) && done;
        result.conn_persist = (err == ERR_NONE) ? seen_next : seen_reg;
        result.error_code   = err;

        // done or error: start a new block
        if ((err != ERR_NONE) || done)
        begin
            phase_next  = PH_START;
            offset_next = '0;
            kpos_next   = '0;
            kok_next    = 1'b1;
            vpos_next   = '0;
            vok_next    = 1'b1;
            seen_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            offset_reg <= '0;
            kpos_reg   <= '0;
            kok_reg    <= 1'b1;
            vpos_reg   <= '0;
            vok_reg    <= 1'b1;
            seen_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            kpos_reg   <= kpos_next;
            kok_reg    <= kok_next;
            vpos_reg   <= vpos_next;
            vok_reg    <= vok_next;
            seen_reg   <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.block_done) |=> (phase_reg == PH_START) && !seen_reg)
        else $error("block end did not restart the parser");

    a_error_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (result.error_code != ERR_NONE)) |=> (phase_reg == PH_START))
        else $error("error did not restart the parser");

    a_pair_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.pair_done) |=> (phase_reg == PH_LF))
        else $error("pair completion did not move to line-feed phase");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (kpos_reg <= MATCH_FULL) && (vpos_reg <= MATCH_FULL))
        else $error("match position past word length");
`endif

endmodule

// ===== sv/http_header_block_parser_top.sv =====
// HTTP header block parser.
// in_ch carries one raw header byte per item (byte_in) plus end_of_data,
// which marks the last byte currently available. out_ch returns exactly one
// item per input byte: the byte, its role, pair/block completion flags, the
// keep-alive flag of the current block and an error code.
// cfg_we/cfg_wdata write value_limit (reset 255); the user must do so only
// while the block is idle, as the block does not enforce it. Each byte is
// parsed in the cycle it is accepted, against the parser state registers,
// and its result is registered, valid on out_ch in the next cycle; a new
// byte is accepted every cycle unless out_ch stalls. The single output
// register sets the rate: in_ch.ready is high when that register is empty
// or is being drained in the same cycle. When the receiver stalls, the
// output item holds and in_ch.ready drops until it is taken; parser state
// does not advance while no byte is accepted. Reset clears the output
// register and returns the parser to the start of a block with value_limit
// at 255. After a block end or an error the next byte begins a new block.
module http_header_block_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    hpp_in_if.sink                        in_ch,
    hpp_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [hpp_pkg::LIMIT_W-1:0]   cfg_wdata
);
    import hpp_pkg::*;

    logic               accept;
    logic               out_valid_reg;
    result_t            out_item_reg;
    result_t            result;
    logic [LIMIT_W-1:0] value_limit_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    hpp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .byte_in     (in_ch.byte_in),
        .end_of_data (in_ch.end_of_data),
        .value_limit (value_limit_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_limit_reg <= VALUE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            value_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    // payload register: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_out     = out_item_reg.byte_out;
    assign out_ch.role         = out_item_reg.role;
    assign out_ch.pair_done    = out_item_reg.pair_done;
    assign out_ch.block_done   = out_item_reg.block_done;
    assign out_ch.conn_persist = out_item_reg.conn_persist;
    assign out_ch.error_code   = out_item_reg.error_code;

endmodule
